// ----- rtl/trsp_pkg.sv -----
// Shared types and constants for the tree record stream parser.
// Used by trsp_parse, trsp_rbuf and tree_record_stream_parser_unit; depends on nothing.
package trsp_pkg;

  // Default record geometry
  localparam int unsigned HashBytesDef  = 32;
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned NameBytesDef  = 256;

  // Result queue geometry
  localparam int unsigned RbufDepth = 4;
  localparam int unsigned RbufPtrW  = $clog2(RbufDepth);
  localparam int unsigned RbufCntW  = $clog2(RbufDepth + 1);

  // Characters that steer the record parse
  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrSeven = 8'h37;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_HASH  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // Parse phases within a record
  typedef enum logic [1:0] {
    PH_MODE = 2'd0,
    PH_NAME = 2'd1,
    PH_HASH = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // One result transaction
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  pos;
    logic [31:0] mode;
    logic [5:0]  entry;
    logic [7:0]  len;
    logic        fin;
    logic        last;
  } res_t;

endpackage

// ----- rtl/trsp_parse.sv -----
// Record phase machine: turns one accepted byte into zero, one or two results.
// Depends on trsp_pkg.
module trsp_parse #(
  parameter int unsigned HASH_BYTES  = trsp_pkg::HashBytesDef,
  parameter int unsigned MAX_ENTRIES = trsp_pkg::MaxEntriesDef,
  parameter int unsigned NAME_BYTES  = trsp_pkg::NameBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        byte_in,
  input  logic              eod,
  output trsp_pkg::res_t    res0,
  output trsp_pkg::res_t    res1,
  output logic [1:0]        res_cnt
);
  import trsp_pkg::*;

  phase_t      phase_r,   phase_nxt;
  logic [31:0] mode_r,    mode_nxt;
  logic        stopped_r, stopped_nxt;
  logic [7:0]  name_r,    name_nxt;
  logic [5:0]  hash_r,    hash_nxt;
  logic [6:0]  ent_r,     ent_nxt;

  logic        name_room;
  logic        hash_done;
  logic        lim;
  logic        is_digit;
  res_t        err_res;
  res_t        name_res;
  res_t        hash_res;
  res_t        entry_res;

  // Record progress tests
  assign name_room = {1'b0, name_r} < 9'(NAME_BYTES - 1);
  assign hash_done = ({1'b0, hash_r} + 7'd1) >= 7'(HASH_BYTES);
  assign lim       = ({1'b0, ent_r} + 8'd1) >= 8'(MAX_ENTRIES);
  assign is_digit  = (byte_in >= ChrZero) && (byte_in <= ChrSeven);

  // Candidate results
  always_comb begin
    err_res       = '0;
    err_res.kind  = KIND_ERROR;
    err_res.entry = ent_r[5:0];

    name_res       = '0;
    name_res.kind  = KIND_NAME;
    name_res.data  = byte_in;
    name_res.pos   = name_r;
    name_res.entry = ent_r[5:0];

    hash_res       = '0;
    hash_res.kind  = KIND_HASH;
    hash_res.data  = byte_in;
    hash_res.pos   = {2'b00, hash_r};
    hash_res.entry = ent_r[5:0];

    entry_res       = '0;
    entry_res.kind  = KIND_ENTRY;
    entry_res.mode  = mode_r;
    entry_res.entry = ent_r[5:0];
    entry_res.len   = name_r;
    entry_res.fin   = lim | eod;
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MODE;
      mode_r    <= '0;
      stopped_r <= 1'b0;
      name_r    <= '0;
      hash_r    <= '0;
      ent_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      mode_r    <= mode_nxt;
      stopped_r <= stopped_nxt;
      name_r    <= name_nxt;
      hash_r    <= hash_nxt;
      ent_r     <= ent_nxt;
    end
  end

  // Advance the phase and pick results
  always_comb begin
    phase_nxt   = phase_r;
    mode_nxt    = mode_r;
    stopped_nxt = stopped_r;
    name_nxt    = name_r;
    hash_nxt    = hash_r;
    ent_nxt     = ent_r;
    res0        = '0;
    res1        = '0;
    res_cnt     = 2'd0;

    if (take) begin
      case (phase_r)
        PH_MODE: begin
          if (byte_in == ChrSpace) begin
            phase_nxt = PH_NAME;
            name_nxt  = '0;
            if (eod) begin
              res0    = err_res;
              res_cnt = 2'd1;
            end
          end else if (byte_in == ChrNul) begin
            res0      = err_res;
            res_cnt   = 2'd1;
            phase_nxt = PH_SKIP;
          end else begin
            if (!stopped_r && is_digit) begin
              mode_nxt = (mode_r << 3) + {29'd0, byte_in[2:0]};
            end else begin
              stopped_nxt = 1'b1;
            end
            if (eod) begin
              res0    = err_res;
              res_cnt = 2'd1;
            end
          end
        end
        PH_NAME: begin
          if (byte_in == ChrNul) begin
            phase_nxt = PH_HASH;
            hash_nxt  = '0;
            if (eod) begin
              res0    = err_res;
              res_cnt = 2'd1;
            end
          end else if (name_room) begin
            res0     = name_res;
            name_nxt = name_r + 8'd1;
            if (eod) begin
              res1    = err_res;
              res_cnt = 2'd2;
            end else begin
              res_cnt = 2'd1;
            end
          end else if (eod) begin
            res0    = err_res;
            res_cnt = 2'd1;
          end
        end
        PH_HASH: begin
          res0 = hash_res;
          if (hash_done) begin
            res1        = entry_res;
            res_cnt     = 2'd2;
            ent_nxt     = ent_r + 7'd1;
            mode_nxt    = '0;
            stopped_nxt = 1'b0;
            name_nxt    = '0;
            hash_nxt    = '0;
            phase_nxt   = lim ? PH_SKIP : PH_MODE;
          end else begin
            hash_nxt = hash_r + 6'd1;
            if (eod) begin
              res1    = err_res;
              res_cnt = 2'd2;
            end else begin
              res_cnt = 2'd1;
            end
          end
        end
        default: begin
        end
      endcase

      // Mark the final result of this byte
      if (res_cnt == 2'd1) begin
        res0.last = 1'b1;
      end else if (res_cnt == 2'd2) begin
        res1.last = 1'b1;
      end

      // End of object: back to reset state for the next one
      if (eod) begin
        phase_nxt   = PH_MODE;
        mode_nxt    = '0;
        stopped_nxt = 1'b0;
        name_nxt    = '0;
        hash_nxt    = '0;
        ent_nxt     = '0;
      end
    end
  end

endmodule

// ----- rtl/trsp_rbuf.sv -----
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on trsp_pkg.
module trsp_rbuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trsp_pkg::res_t                wr0,
  input  trsp_pkg::res_t                wr1,
  input  logic [1:0]                    wr_cnt,
  input  logic                          pop,
  output trsp_pkg::res_t                rd,
  output logic                          not_empty,
  output logic                          room2
);
  import trsp_pkg::*;

  res_t                 mem [RbufDepth];
  logic [RbufPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [RbufPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [RbufCntW-1:0]  cnt_r,    cnt_nxt;
  logic [RbufPtrW-1:0]  wr_ptr_p1;
  logic                 do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign wr_ptr_p1 = wr_ptr_r + RbufPtrW'(1);
  assign not_empty = cnt_r != '0;
  assign room2     = cnt_r <= RbufCntW'(RbufDepth - 2);
  assign rd        = mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RbufPtrW'(wr_cnt);
    rd_ptr_nxt = do_pop ? rd_ptr_r + RbufPtrW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + RbufCntW'(wr_cnt) - RbufCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store incoming results in order
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wr_ptr_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= wr1;
    end
  end

endmodule

// ----- rtl/tree_record_stream_parser_unit.sv -----
// Tree record stream parser: top level, byte input channel and result channel.
// Depends on trsp_pkg, trsp_parse and trsp_rbuf.
//
// Takes one byte of a tree object per cycle and parses records of octal mode,
// space, zero-terminated name and a HASH_BYTES-byte hash. Each byte updates the
// phase machine in trsp_parse in the cycle it is accepted, and its results
// (none, one or two) are written into a four-entry result queue at the accepting
// edge, so the first of them can be offered in the following cycle; results
// leave one per cycle while out_stall is low. in_stall rises while fewer than
// two queue slots are free, so the sustained rate is one byte per cycle as
// long as the result side keeps up; a byte that yields two results (last hash
// byte, or a name or hash byte on which the object ends early) adds an extra
// result. A byte flagged in_end_of_data resets the parser for the next object.
module tree_record_stream_parser_unit #(
  parameter int unsigned HASH_BYTES  = trsp_pkg::HashBytesDef,
  parameter int unsigned MAX_ENTRIES = trsp_pkg::MaxEntriesDef,
  parameter int unsigned NAME_BYTES  = trsp_pkg::NameBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_byte_pos,
  output logic [31:0] out_entry_mode,
  output logic [5:0]  out_entry_number,
  output logic [7:0]  out_name_length,
  output logic        out_parse_finished,
  output logic        out_last
);
  import trsp_pkg::*;

  logic       take;
  logic       room2;
  res_t       res0;
  res_t       res1;
  res_t       rd;
  logic [1:0] res_cnt;

  // Accept a transaction when two result slots are free
  assign in_stall = !room2;
  assign take     = in_valid && room2;

  trsp_parse #(
    .HASH_BYTES  (HASH_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES),
    .NAME_BYTES  (NAME_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_byte),
    .eod     (in_end_of_data),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  trsp_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr0       (res0),
    .wr1       (res1),
    .wr_cnt    (res_cnt),
    .pop       (!out_stall),
    .rd        (rd),
    .not_empty (out_valid),
    .room2     (room2)
  );

  // Drive result ports from the queue head
  assign out_kind           = rd.kind;
  assign out_byte           = rd.data;
  assign out_byte_pos       = rd.pos;
  assign out_entry_mode     = rd.mode;
  assign out_entry_number   = rd.entry;
  assign out_name_length    = rd.len;
  assign out_parse_finished = rd.fin;
  assign out_last           = rd.last;

endmodule
